// ===== design/pmcf_pkg.sv =====
// pmcf_pkg: shared constants and types for the pattern mask crossfade core
// register indexes, command codes, reset values and default sizes
// no dependencies
package pmcf_pkg;

    localparam int PATTERN_MAX_SIDE_DEF = 256;
    localparam int SCREEN_MAX_WIDTH_DEF = 4096;

    localparam int PHASE_W      = 8;
    localparam int PSIZE_W      = 9;
    localparam int SSIZE_W      = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int CHAN_W       = 8;
    localparam int ADDR_IN_W    = 16;

    localparam logic [PHASE_W-1:0] PHASE_RST          = 8'd0;
    localparam logic [PSIZE_W-1:0] PATTERN_WIDTH_RST  = 9'd256;
    localparam logic [PSIZE_W-1:0] PATTERN_HEIGHT_RST = 9'd256;
    localparam logic [SSIZE_W-1:0] SCREEN_WIDTH_RST   = 13'd640;

    localparam logic [CHAN_W-1:0] FULL_WEIGHT = 8'hFF;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_BLEND = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE          = 2'd0,
        CFG_PATTERN_WIDTH  = 2'd1,
        CFG_PATTERN_HEIGHT = 2'd2,
        CFG_SCREEN_WIDTH   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

endpackage

// ===== design/pattern_mask_crossfade_core.sv =====
// pattern_mask_crossfade_core: blends two rgb streams through a tiled pattern image
// pattern store, position counters, weight and channel mix; uses pmcf_pkg
// an accepted blend request passes through stage 1 and the output register to m_axis_tvalid
// throughput: one request per cycle, loads and blends alike, unless m_axis back-pressure stalls
// stage 1; set by the single write port and single registered read port of the pattern store
// reset: rst_n clears valids and counters and restores register defaults at once;
// the pattern store is not cleared and must be loaded before it is read
module pattern_mask_crossfade_core #(
    parameter int PATTERN_MAX_SIDE = pmcf_pkg::PATTERN_MAX_SIDE_DEF,
    parameter int SCREEN_MAX_WIDTH = pmcf_pkg::SCREEN_MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pmcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmcf_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pattern_addr[15:0], pattern_value[23:16], before_red[31:24], before_green[39:32],
    // before_blue[47:40], after_red[55:48], after_green[63:56], after_blue[71:64]
    input  logic [71:0] s_axis_tdata,
    // command[0], start_of_frame[1]
    input  logic [1:0]  s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mixed_red[7:0], mixed_green[15:8], mixed_blue[23:16]
    output logic [23:0] m_axis_tdata
);

    localparam int DEPTH = PATTERN_MAX_SIDE * PATTERN_MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(PATTERN_MAX_SIDE);
    localparam int PWW   = $clog2(PATTERN_MAX_SIDE + 1);
    localparam int PRW   = CW + PWW;
    localparam int SCW   = $clog2(SCREEN_MAX_WIDTH);
    localparam int SWW   = $clog2(SCREEN_MAX_WIDTH + 1);
    localparam int CH    = pmcf_pkg::CHAN_W;

    // configuration registers
    logic [pmcf_pkg::PHASE_W-1:0] phase_reg;
    logic [pmcf_pkg::PSIZE_W-1:0] pattern_width_reg;
    logic [pmcf_pkg::PSIZE_W-1:0] pattern_height_reg;
    logic [pmcf_pkg::SSIZE_W-1:0] screen_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= pmcf_pkg::PHASE_RST;
            pattern_width_reg  <= pmcf_pkg::PATTERN_WIDTH_RST;
            pattern_height_reg <= pmcf_pkg::PATTERN_HEIGHT_RST;
            screen_width_reg   <= pmcf_pkg::SCREEN_WIDTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (pmcf_pkg::cfg_index_t'(cfg_index))
                pmcf_pkg::CFG_PHASE:
                    phase_reg <= cfg_data[pmcf_pkg::PHASE_W-1:0];
                pmcf_pkg::CFG_PATTERN_WIDTH:
                    pattern_width_reg <= cfg_data[pmcf_pkg::PSIZE_W-1:0];
                pmcf_pkg::CFG_PATTERN_HEIGHT:
                    pattern_height_reg <= cfg_data[pmcf_pkg::PSIZE_W-1:0];
                pmcf_pkg::CFG_SCREEN_WIDTH:
                    screen_width_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // effective sizes: zero acts as one, oversize saturates
    logic [PWW-1:0] pw_eff;
    logic [PWW-1:0] ph_eff;
    logic [SWW-1:0] sw_eff;

    always_comb
    begin
        if (pattern_width_reg == '0)
            pw_eff = PWW'(1);
        else if (32'(pattern_width_reg) > 32'(PATTERN_MAX_SIDE))
            pw_eff = PWW'(PATTERN_MAX_SIDE);
        else
            pw_eff = PWW'(pattern_width_reg);

        if (pattern_height_reg == '0)
            ph_eff = PWW'(1);
        else if (32'(pattern_height_reg) > 32'(PATTERN_MAX_SIDE))
            ph_eff = PWW'(PATTERN_MAX_SIDE);
        else
            ph_eff = PWW'(pattern_height_reg);

        if (screen_width_reg == '0)
            sw_eff = SWW'(1);
        else if (32'(screen_width_reg) > 32'(SCREEN_MAX_WIDTH))
            sw_eff = SWW'(SCREEN_MAX_WIDTH);
        else
            sw_eff = SWW'(screen_width_reg);
    end

    // input unpacking
    logic                            in_cmd;
    logic                            in_sof;
    logic [pmcf_pkg::ADDR_IN_W-1:0]  in_addr;
    logic [CH-1:0]                   in_value;
    pmcf_pkg::rgb_t                  in_before;
    pmcf_pkg::rgb_t                  in_after;

    assign in_cmd          = s_axis_tuser[0];
    assign in_sof          = s_axis_tuser[1];
    assign in_addr         = s_axis_tdata[15:0];
    assign in_value        = s_axis_tdata[23:16];
    assign in_before.red   = s_axis_tdata[31:24];
    assign in_before.green = s_axis_tdata[39:32];
    assign in_before.blue  = s_axis_tdata[47:40];
    assign in_after.red    = s_axis_tdata[55:48];
    assign in_after.green  = s_axis_tdata[63:56];
    assign in_after.blue   = s_axis_tdata[71:64];

    // pipeline control
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_free;
    logic in_accept;
    logic acc_blend;
    logic acc_load;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign acc_blend     = in_accept && (in_cmd == pmcf_pkg::CMD_BLEND);
    assign acc_load      = in_accept && (in_cmd == pmcf_pkg::CMD_LOAD);

    // position counters
    logic [CW-1:0]  pattern_col_reg;
    logic [CW-1:0]  pattern_row_reg;
    logic [SCW-1:0] screen_col_reg;
    logic [CW-1:0]  pattern_col_next;
    logic [CW-1:0]  pattern_row_next;
    logic [SCW-1:0] screen_col_next;
    logic [CW-1:0]  base_col;
    logic [CW-1:0]  base_row;
    logic [SCW-1:0] base_scol;
    logic [CW:0]    col_inc;
    logic [CW:0]    row_inc;
    logic [SCW:0]   scol_inc;
    logic [PRW-1:0] row_offset;
    logic [AW-1:0]  rd_addr;

    always_comb
    begin
        base_col  = in_sof ? '0 : pattern_col_reg;
        base_row  = in_sof ? '0 : pattern_row_reg;
        base_scol = in_sof ? '0 : screen_col_reg;

        row_offset = PRW'(base_row) * PRW'(pw_eff);
        rd_addr    = AW'(row_offset + PRW'(base_col));

        col_inc  = (CW + 1)'(base_col) + (CW + 1)'(1);
        row_inc  = (CW + 1)'(base_row) + (CW + 1)'(1);
        scol_inc = (SCW + 1)'(base_scol) + (SCW + 1)'(1);

        pattern_col_next = pattern_col_reg;
        pattern_row_next = pattern_row_reg;
        screen_col_next  = screen_col_reg;

        if (acc_blend)
        begin
            if (32'(col_inc) >= 32'(pw_eff))
                pattern_col_next = '0;
            else
                pattern_col_next = col_inc[CW-1:0];
            pattern_row_next = base_row;
            screen_col_next  = scol_inc[SCW-1:0];
            // end of screen row: restart pattern column, step pattern row
            if (32'(scol_inc) >= 32'(sw_eff))
            begin
                screen_col_next  = '0;
                pattern_col_next = '0;
                if (32'(row_inc) >= 32'(ph_eff))
                    pattern_row_next = '0;
                else
                    pattern_row_next = row_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_col_reg <= '0;
            pattern_row_reg <= '0;
            screen_col_reg  <= '0;
        end
        else
        begin
            pattern_col_reg <= pattern_col_next;
            pattern_row_reg <= pattern_row_next;
            screen_col_reg  <= screen_col_next;
        end
    end

    // pattern store, one write port and one registered read port
    logic [CH-1:0] pattern_mem [DEPTH];
    logic [CH-1:0] pat_reg;

    always_ff @(posedge clk)
    begin
        if (acc_load && (32'(in_addr) < 32'(DEPTH)))
            pattern_mem[AW'(in_addr)] <= in_value;
    end

    always_ff @(posedge clk)
    begin
        if (acc_blend)
            pat_reg <= pattern_mem[rd_addr];
    end

    // stage 1: pixel waits beside the pattern byte
    pmcf_pkg::rgb_t before_reg;
    pmcf_pkg::rgb_t after_reg;

    always_ff @(posedge clk)
    begin
        if (acc_blend)
        begin
            before_reg <= in_before;
            after_reg  <= in_after;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc_blend)
            s1_valid_next = 1'b1;
        else if (out_free)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // weight and mix
    logic signed [CH+1:0] raw_weight;
    logic [CH-1:0]        weight;
    logic [CH-1:0]        inv_weight;
    pmcf_pkg::rgb_t       mixed;
    logic [2*CH-1:0]      sum_red;
    logic [2*CH-1:0]      sum_green;
    logic [2*CH-1:0]      sum_blue;

    always_comb
    begin
        raw_weight = $signed({1'b0, phase_reg, 1'b0}) - $signed({2'b00, pat_reg});
        if (raw_weight < 0)
            weight = '0;
        else if (raw_weight > $signed({2'b00, pmcf_pkg::FULL_WEIGHT}))
            weight = pmcf_pkg::FULL_WEIGHT;
        else
            weight = raw_weight[CH-1:0];
        inv_weight = pmcf_pkg::FULL_WEIGHT - weight;

        // a*w + b*(255-w) never exceeds 255*255, so 16 bits hold it
        sum_red   = (2*CH)'(after_reg.red) * (2*CH)'(weight)
                  + (2*CH)'(before_reg.red) * (2*CH)'(inv_weight);
        sum_green = (2*CH)'(after_reg.green) * (2*CH)'(weight)
                  + (2*CH)'(before_reg.green) * (2*CH)'(inv_weight);
        sum_blue  = (2*CH)'(after_reg.blue) * (2*CH)'(weight)
                  + (2*CH)'(before_reg.blue) * (2*CH)'(inv_weight);

        mixed.red   = sum_red[2*CH-1:CH];
        mixed.green = sum_green[2*CH-1:CH];
        mixed.blue  = sum_blue[2*CH-1:CH];
    end

    // output register
    pmcf_pkg::rgb_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_valid_reg && out_free)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_free)
            out_data_reg <= mixed;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.blue, out_data_reg.green, out_data_reg.red};

`ifndef SYNTHESIS
    // an accepted blend always lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_blend |=> s1_valid_reg)
    else $error("blend request lost before stage 1");

    // a load into an empty stage 1 produces no pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_load && !s1_valid_reg) |=> !s1_valid_reg)
    else $error("load request produced a pixel");

    // a new output pixel comes only from a filled stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_valid_reg))
    else $error("output valid without stage 1 data");

    // frame start restarts the screen column
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_blend && in_sof) |=> (screen_col_reg <= SCW'(1)))
    else $error("screen column not restarted at frame start");
`endif

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for pattern_mask_crossfade_core, directed table then random segments
// keeps its own pattern store, position counters and registers to predict every blended pixel
// depends on pmcf_pkg and the core; needs no files or arguments
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic              cmd;
        logic              sof;
        logic [15:0]       addr;
        logic [7:0]        value;
        pmcf_pkg::rgb_t    prior;
        pmcf_pkg::rgb_t    after;
    } pix_req_t;

    typedef enum logic {ROW_REG, ROW_REQ} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        pmcf_pkg::cfg_index_t reg_idx;
        logic [12:0]          reg_data;
        pix_req_t             req;
        logic                 typed;
        pmcf_pkg::rgb_t       mixed;
    } dir_row_t;

    // rgb literals read as blue, green, red from the left
    localparam int DIR_ROWS = 28;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // loads, the first one with start_of_frame set, which a load ignores
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_LOAD, 1'b1, 16'h0000, 8'h00, 24'h0, 24'h0}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_LOAD, 1'b0, 16'hFFFF, 8'hFF, 24'h0, 24'h0}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_LOAD, 1'b0, 16'h0001, 8'h00, 24'h0, 24'h0}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_LOAD, 1'b0, 16'h0002, 8'hC8, 24'h0, 24'h0}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_LOAD, 1'b0, 16'h0003, 8'h96, 24'h0, 24'h0}, 1'b0, 24'h0},
        // phase 0 after reset: weight clamps to zero, output is the before pixel scaled
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b1, 16'h0, 8'h0, 24'hFFFFFF, 24'h000000}, 1'b1, 24'hFEFEFE},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'h000000, 24'hFFFFFF}, 1'b1, 24'h000000},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'hFFFFFF, 24'hFFFFFF}, 1'b1, 24'hFEFEFE},
        // full phase: weight saturates high
        '{ROW_REG, pmcf_pkg::CFG_PHASE, 13'h0FF, '0, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b1, 16'h0, 8'h0, 24'h000000, 24'hFFFFFF}, 1'b1, 24'hFEFEFE},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'hFFFFFF, 24'h000000}, 1'b1, 24'h000000},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'h563412, 24'hEFCDAB}, 1'b0, 24'h0},
        // mid phase: weights inside the range, one of them exactly zero
        '{ROW_REG, pmcf_pkg::CFG_PHASE, 13'd100, '0, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b1, 16'h0, 8'h0, 24'hA5C3E1, 24'h1E3C5A}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'h80FF01, 24'h7F00FE}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'h0F1E2D, 24'hF0E1D2}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'hC0FFEE, 24'h123456}, 1'b0, 24'h0},
        // zero sizes act as one; the column counter stays beyond the shrunk width once
        '{ROW_REG, pmcf_pkg::CFG_PATTERN_WIDTH, 13'd0, '0, 1'b0, 24'h0},
        '{ROW_REG, pmcf_pkg::CFG_PATTERN_HEIGHT, 13'd0, '0, 1'b0, 24'h0},
        '{ROW_REG, pmcf_pkg::CFG_SCREEN_WIDTH, 13'd0, '0, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_LOAD, 1'b0, 16'h0004, 8'h80, 24'h0, 24'h0}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'h336699, 24'hCC9966}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'h010203, 24'hFDFEFF}, 1'b0, 24'h0},
        // oversized values saturate to the maximum sizes
        '{ROW_REG, pmcf_pkg::CFG_PATTERN_WIDTH, 13'h1FF, '0, 1'b0, 24'h0},
        '{ROW_REG, pmcf_pkg::CFG_PATTERN_HEIGHT, 13'h1FF, '0, 1'b0, 24'h0},
        '{ROW_REG, pmcf_pkg::CFG_SCREEN_WIDTH, 13'h1FFF, '0, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b1, 16'h0, 8'h0, 24'h445566, 24'hAABBCC}, 1'b0, 24'h0},
        '{ROW_REQ, pmcf_pkg::CFG_PHASE, 13'd0,
          '{pmcf_pkg::CMD_BLEND, 1'b0, 16'h0, 8'h0, 24'h998877, 24'h112233}, 1'b0, 24'h0}
    };

    localparam int RANDOM_REQS = 1100;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [pmcf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pmcf_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    // predictor state
    logic [7:0]  pattern_shadow [65536];
    bit          pattern_loaded [65536];
    logic [7:0]  pat_col;
    logic [7:0]  pat_row;
    logic [11:0] scr_col;
    logic [7:0]  phase_r;
    logic [8:0]  pw_r;
    logic [8:0]  ph_r;
    logic [12:0] sw_r;

    pmcf_pkg::rgb_t mixed_q [$];
    int          err_count;
    int          accepted_reqs;
    bit          no_gaps;

    pattern_mask_crossfade_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int clamp_size(int v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int cur_pattern_addr();
        return int'(pat_row) * clamp_size(pw_r, pmcf_pkg::PATTERN_MAX_SIDE_DEF) + int'(pat_col);
    endfunction

    function automatic logic [7:0] fade_channel(logic [7:0] b, logic [7:0] a, int w);
        int acc;
        acc = int'(a) * w + int'(b) * (int'(pmcf_pkg::FULL_WEIGHT) - w);
        return acc[15:8];
    endfunction

    function automatic pmcf_pkg::rgb_t rand_rgb();
        pmcf_pkg::rgb_t c;
        c.red   = ($urandom_range(9) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
        c.green = ($urandom_range(9) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
        c.blue  = ($urandom_range(9) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
        return c;
    endfunction

    function automatic logic [8:0] pick_side();
        case ($urandom_range(9))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd256;
            3: return 9'd511;
            4: return 9'($urandom_range(511));
            default: return 9'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [12:0] pick_screen();
        case ($urandom_range(9))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd4096;
            3: return 13'd8191;
            4: return 13'($urandom_range(8191));
            default: return 13'($urandom_range(1, 48));
        endcase
    endfunction

    // registers only change with nothing in flight; loads leave no result to wait on
    task automatic write_reg(input pmcf_pkg::cfg_index_t idx, input logic [12:0] data);
        s_axis_tvalid <= 1'b0;
        while (mixed_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pmcf_pkg::CFG_PHASE:          phase_r = data[7:0];
            pmcf_pkg::CFG_PATTERN_WIDTH:  pw_r    = data[8:0];
            pmcf_pkg::CFG_PATTERN_HEIGHT: ph_r    = data[8:0];
            pmcf_pkg::CFG_SCREEN_WIDTH:   sw_r    = data[12:0];
            default: ;
        endcase
    endtask

    task automatic issue_request(input pix_req_t r, input bit typed,
                                 input pmcf_pkg::rgb_t typed_mix);
        int             pat;
        int             wgt;
        pmcf_pkg::rgb_t pred;
        while (!no_gaps && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.after, r.prior, r.value, r.addr};
        s_axis_tuser  <= {r.sof, r.cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        accepted_reqs++;
        if (r.cmd == pmcf_pkg::CMD_LOAD)
        begin
            pattern_shadow[r.addr] = r.value;
            pattern_loaded[r.addr] = 1'b1;
        end
        else
        begin
            if (r.sof)
            begin
                pat_col = '0;
                pat_row = '0;
                scr_col = '0;
            end
            pat = pattern_shadow[cur_pattern_addr()];
            wgt = 2 * int'(phase_r) - pat;
            if (wgt < 0)
                wgt = 0;
            else if (wgt > int'(pmcf_pkg::FULL_WEIGHT))
                wgt = int'(pmcf_pkg::FULL_WEIGHT);
            pred.red   = fade_channel(r.prior.red, r.after.red, wgt);
            pred.green = fade_channel(r.prior.green, r.after.green, wgt);
            pred.blue  = fade_channel(r.prior.blue, r.after.blue, wgt);
            mixed_q.push_back(typed ? typed_mix : pred);
            // counters may sit beyond a shrunk size; columns wrap here, the row only at screen row end
            if (int'(pat_col) + 1 >= clamp_size(pw_r, pmcf_pkg::PATTERN_MAX_SIDE_DEF))
                pat_col = '0;
            else
                pat_col++;
            if (int'(scr_col) + 1 >= clamp_size(sw_r, pmcf_pkg::SCREEN_MAX_WIDTH_DEF))
            begin
                scr_col = '0;
                pat_col = '0;
                if (int'(pat_row) + 1 >= clamp_size(ph_r, pmcf_pkg::PATTERN_MAX_SIDE_DEF))
                    pat_row = '0;
                else
                    pat_row++;
            end
            else
                scr_col++;
        end
    endtask

    // result side: random backpressure unless no_gaps is set, in-order compare against the oldest prediction
    always @(posedge clk)
    begin
        pmcf_pkg::rgb_t got;
        pmcf_pkg::rgb_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (mixed_q.size() == 0)
                begin
                    $error("unexpected result %h", m_axis_tdata);
                    err_count++;
                end
                else
                begin
                    want = mixed_q.pop_front();
                    if (got.red !== want.red)
                    begin
                        $error("mixed_red: expected %h, got %h", want.red, got.red);
                        err_count++;
                    end
                    if (got.green !== want.green)
                    begin
                        $error("mixed_green: expected %h, got %h", want.green, got.green);
                        err_count++;
                    end
                    if (got.blue !== want.blue)
                    begin
                        $error("mixed_blue: expected %h, got %h", want.blue, got.blue);
                        err_count++;
                    end
                end
            end
            m_axis_tready <= no_gaps || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        pix_req_t r;
        pix_req_t fill;
        int       rand_base;
        int       seg_len;
        int       region;
        int       addr;
        int       done_reqs;
        bit       first_seg;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        err_count     = 0;
        accepted_reqs = 0;
        no_gaps       = 1'b0;
        pat_col       = '0;
        pat_row       = '0;
        scr_col       = '0;
        phase_r       = pmcf_pkg::PHASE_RST;
        pw_r          = pmcf_pkg::PATTERN_WIDTH_RST;
        ph_r          = pmcf_pkg::PATTERN_HEIGHT_RST;
        sw_r          = pmcf_pkg::SCREEN_WIDTH_RST;
        first_seg     = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].kind == ROW_REG)
                write_reg(DIR_TABLE[i].reg_idx, DIR_TABLE[i].reg_data);
            else
                issue_request(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].mixed);
        end

        // random segments, each after random rewrites of some registers (all of them before the first)
        rand_base = accepted_reqs;
        while (accepted_reqs - rand_base < RANDOM_REQS)
        begin
            if (first_seg || $urandom_range(1))
                write_reg(pmcf_pkg::CFG_PHASE, {5'($urandom), ($urandom_range(3) == 0) ?
                          {8{1'($urandom_range(1))}} : 8'($urandom)});
            if (first_seg || $urandom_range(1))
                write_reg(pmcf_pkg::CFG_PATTERN_WIDTH, {4'($urandom), pick_side()});
            if (first_seg || $urandom_range(1))
                write_reg(pmcf_pkg::CFG_PATTERN_HEIGHT, {4'($urandom), pick_side()});
            if (first_seg || $urandom_range(1))
                write_reg(pmcf_pkg::CFG_SCREEN_WIDTH, pick_screen());
            first_seg = 1'b0;
            region = clamp_size(pw_r, pmcf_pkg::PATTERN_MAX_SIDE_DEF) *
                     clamp_size(ph_r, pmcf_pkg::PATTERN_MAX_SIDE_DEF);
            seg_len = $urandom_range(20, 120);
            for (int k = 0; k < seg_len; k++)
            begin
                done_reqs = accepted_reqs - rand_base;
                no_gaps   = (done_reqs >= 600) && (done_reqs < 800);
                r.prior   = rand_rgb();
                r.after   = rand_rgb();
                r.value   = ($urandom_range(9) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
                if ($urandom_range(99) < 30)
                begin
                    r.cmd  = pmcf_pkg::CMD_LOAD;
                    r.sof  = 1'($urandom_range(1));
                    r.addr = $urandom_range(1) ? 16'($urandom_range(region - 1)) : 16'($urandom);
                    issue_request(r, 1'b0, '0);
                end
                else
                begin
                    r.cmd  = pmcf_pkg::CMD_BLEND;
                    r.sof  = (k == 0 && $urandom_range(1)) || ($urandom_range(99) < 4);
                    r.addr = 16'($urandom);
                    addr   = r.sof ? 0 : cur_pattern_addr();
                    // never let a blend read a store entry that was not loaded
                    if (!pattern_loaded[addr])
                    begin
                        fill       = r;
                        fill.cmd   = pmcf_pkg::CMD_LOAD;
                        fill.sof   = 1'($urandom_range(1));
                        fill.addr  = 16'(addr);
                        fill.value = 8'($urandom);
                        issue_request(fill, 1'b0, '0);
                    end
                    issue_request(r, 1'b0, '0);
                end
            end
        end

        no_gaps = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (mixed_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0 && mixed_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pmcf_pkg.sv
design/pattern_mask_crossfade_core.sv
tb/tb.sv
